// File: rtl/biudec_pkg.sv
// Shared types, constants and decode helpers for the bus address decoder.
// No dependencies; every module of the decoder imports it.
package biudec_pkg;

	localparam int PAGE_SHIFT = 12;
	localparam longint PAGE_BYTES = longint'(1) << PAGE_SHIFT;
	localparam longint RAM_BYTES = 2097152;
	localparam longint ROM_BYTES = 4194304;
	localparam longint ROM1_BYTES = 262144;
	localparam int RAM_MIRRORS = 4;

	localparam int ADDR_W = 29;
	localparam int PG_W = ADDR_W - PAGE_SHIFT + 1;
	localparam int OFF_W = 22;
	localparam int KIND_W = 4;

	localparam longint ROM_BASE = 64'h1fc0_0000;
	localparam longint ROM1_BASE = 64'h1e00_0000;
	localparam longint SIF_BASE = 64'h1d00_0000;
	localparam longint HW_BASE = 64'h1f80_0000;
	localparam longint HW_BYTES = PAGE_BYTES * 16;
	localparam longint P1_BASE = 64'h1f80_1000;
	localparam longint P3_BASE = 64'h1f80_3000;
	localparam longint P8_BASE = 64'h1f80_8000;
	localparam longint CDVD_BASE = 64'h1f40_2000;
	localparam longint DEV9_BASE = 64'h1000_0000;
	localparam longint SPU2_BASE = 64'h1f90_0000;
	localparam longint BIU_BASE = 64'h1ffe_0000;
	localparam longint SPAD_BASE = 64'h1f80_0000;

	localparam logic [31:0] BIU_LO = 32'hfffe_0020;
	localparam logic [31:0] BIU_MID = 32'hfffe_0100;
	localparam logic [31:0] BIU_HI = 32'hfffe_0160;
	localparam logic [31:0] BIU_CCTRL = 32'hfffe_0130;
	localparam logic [31:0] BIU_REG_A = 32'hfffe_0140;
	localparam logic [31:0] BIU_REG_B = 32'hfffe_0144;

	localparam logic [KIND_W-1:0] K_RAM = 4'd0;
	localparam logic [KIND_W-1:0] K_ROM = 4'd1;
	localparam logic [KIND_W-1:0] K_ROM1 = 4'd2;
	localparam logic [KIND_W-1:0] K_HW = 4'd3;
	localparam logic [KIND_W-1:0] K_SIF = 4'd4;
	localparam logic [KIND_W-1:0] K_P1 = 4'd5;
	localparam logic [KIND_W-1:0] K_P3 = 4'd6;
	localparam logic [KIND_W-1:0] K_P8 = 4'd7;
	localparam logic [KIND_W-1:0] K_CDVD = 4'd8;
	localparam logic [KIND_W-1:0] K_DEV9 = 4'd9;
	localparam logic [KIND_W-1:0] K_SPU2 = 4'd10;
	localparam logic [KIND_W-1:0] K_BIU = 4'd11;
	localparam logic [KIND_W-1:0] K_NONE = 4'd12;
	localparam logic [KIND_W-1:0] K_NULL = 4'd13;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	localparam logic [1:0] SPM_MAP = 2'd0;
	localparam logic [1:0] SPM_DIRECT = 2'd1;
	localparam logic [1:0] SPM_NULL = 2'd2;
	localparam logic [1:0] SPM_UNMAP = 2'd3;

	typedef struct packed {
		logic func;
		logic [1:0] size;
		logic [31:0] address;
		logic [31:0] write_data;
		logic isolate;
		logic [KIND_W-1:0] kind;
		logic [OFF_W-1:0] offset;
		logic spad;
	} req_t;

	function automatic logic [PG_W-1:0] pg_first(longint base);
		return PG_W'(base >> PAGE_SHIFT);
	endfunction

	function automatic logic [PG_W-1:0] pg_end(longint base, longint bytes);
		return PG_W'((base + bytes + PAGE_BYTES - 1) >> PAGE_SHIFT);
	endfunction

	function automatic logic in_rgn(logic [PG_W-1:0] pg, longint base, longint bytes);
		return (pg >= pg_first(base)) && (pg < pg_end(base, bytes));
	endfunction

	function automatic logic [OFF_W-1:0] rgn_off(logic [ADDR_W-1:0] m, longint base);
		logic [ADDR_W-1:0] start;
		start = ADDR_W'({pg_first(base), {PAGE_SHIFT{1'b0}}});
		return OFF_W'(m - start);
	endfunction

endpackage

// File: rtl/biudec_front.sv
// Front end: takes the request, normalizes the width and decodes the fixed page map.
// Scratchpad mode is resolved later in the back end. Depends on biudec_pkg.
module biudec_front (
	input  logic               in_valid,
	input  logic               q_full,
	input  logic               func,
	input  logic [1:0]         size_code,
	input  logic [31:0]        address,
	input  logic [31:0]        write_data,
	input  logic               isolate,
	output logic               in_stall,
	output logic               push,
	output biudec_pkg::req_t   req
);
	import biudec_pkg::*;

	logic [ADDR_W-1:0] m;
	logic [PG_W-1:0] pg;
	logic [KIND_W-1:0] kind;
	logic [OFF_W-1:0] off;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;
	assign m = address[ADDR_W-1:0];
	assign pg = PG_W'(m[ADDR_W-1:PAGE_SHIFT]);

	// later regions override earlier ones
	always_comb begin
		kind = K_NONE;
		off = '0;
		for (int i = 0; i < RAM_MIRRORS; i++) begin
			if (in_rgn(pg, RAM_BYTES * i, RAM_BYTES)) begin
				kind = K_RAM;
				off = rgn_off(m, RAM_BYTES * i);
			end
		end
		if (in_rgn(pg, ROM_BASE, ROM_BYTES)) begin
			kind = K_ROM;
			off = rgn_off(m, ROM_BASE);
		end
		if (in_rgn(pg, ROM1_BASE, ROM1_BYTES)) begin
			kind = K_ROM1;
			off = rgn_off(m, ROM1_BASE);
		end
		if (in_rgn(pg, SIF_BASE, PAGE_BYTES)) begin
			kind = K_SIF;
			off = '0;
		end
		if (in_rgn(pg, HW_BASE, HW_BYTES)) begin
			kind = K_HW;
			off = rgn_off(m, HW_BASE);
		end
		if (in_rgn(pg, P1_BASE, PAGE_BYTES)) begin
			kind = K_P1;
			off = '0;
		end
		if (in_rgn(pg, P3_BASE, PAGE_BYTES)) begin
			kind = K_P3;
			off = '0;
		end
		if (in_rgn(pg, P8_BASE, PAGE_BYTES)) begin
			kind = K_P8;
			off = '0;
		end
		if (in_rgn(pg, CDVD_BASE, PAGE_BYTES)) begin
			kind = K_CDVD;
			off = '0;
		end
		if (in_rgn(pg, DEV9_BASE, PAGE_BYTES)) begin
			kind = K_DEV9;
			off = '0;
		end
		if (in_rgn(pg, SPU2_BASE, PAGE_BYTES)) begin
			kind = K_SPU2;
			off = '0;
		end
		if (in_rgn(pg, BIU_BASE, PAGE_BYTES)) begin
			kind = K_BIU;
			off = '0;
		end
	end

	always_comb begin
		req.func = func;
		req.size = (size_code == 2'd3) ? SZ_WORD : size_code;
		req.address = address;
		req.write_data = write_data;
		req.isolate = isolate;
		req.kind = kind;
		req.offset = off;
		req.spad = in_rgn(pg, SPAD_BASE, PAGE_BYTES);
	end

endmodule

// File: rtl/biudec_queue.sv
// Two-entry request queue between the decode front end and the back end.
// Depends on biudec_pkg for the request type.
module biudec_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  biudec_pkg::req_t   push_req,
	input  logic               pop,
	output logic               full,
	output logic               head_valid,
	output biudec_pkg::req_t   head_req
);
	import biudec_pkg::*;

	req_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_req = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_req;
	end

endmodule

// File: rtl/biudec_back.sv
// Back end: applies scratchpad mode, width limits and the BIU register file,
// then holds the result in the output register. Depends on biudec_pkg.
module biudec_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  biudec_pkg::req_t   head_req,
	input  logic               out_stall,
	output logic               pop,
	output logic               out_valid,
	output logic [3:0]         target,
	output logic [21:0]        offset,
	output logic               bus_error,
	output logic               ignored,
	output logic [31:0]        read_data
);
	import biudec_pkg::*;

	logic [31:0] cctrl_q;
	logic [31:0] reg_a_q;
	logic [31:0] reg_b_q;
	logic [1:0] spm_q;
	logic out_valid_q;
	logic [3:0] target_q;
	logic [OFF_W-1:0] offset_q;
	logic err_q;
	logic ign_q;
	logic [31:0] rdata_q;

	logic [KIND_W-1:0] kind;
	logic [OFF_W-1:0] off;
	logic err, ign;
	logic [31:0] rd, wmask, wval;
	logic [31:0] a;
	logic lt_lo, ge_mid, lt_hi, is_half;
	logic wr_cctrl, wr_a, wr_b;

	assign pop = head_valid && (!out_valid_q || !out_stall);
	assign a = head_req.address;
	assign lt_lo = a < BIU_LO;
	assign ge_mid = a >= BIU_MID;
	assign lt_hi = a < BIU_HI;
	assign is_half = (head_req.size == SZ_HALF);
	assign wval = head_req.write_data & ~32'h0000_0440;

	always_comb begin
		unique case (head_req.size)
			SZ_BYTE: wmask = 32'h0000_00ff;
			SZ_HALF: wmask = 32'h0000_ffff;
			default: wmask = 32'hffff_ffff;
		endcase
	end

	always_comb begin
		kind = head_req.kind;
		off = head_req.offset;
		if (head_req.spad) begin
			unique case (spm_q)
				SPM_DIRECT: begin
					kind = K_HW;
					off = OFF_W'(a[PAGE_SHIFT-1:0]);
				end
				SPM_NULL: begin
					kind = K_NULL;
					off = '0;
				end
				SPM_UNMAP: begin
					kind = K_NONE;
					off = '0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		err = 1'b0;
		ign = 1'b0;
		rd = '0;
		wr_cctrl = 1'b0;
		wr_a = 1'b0;
		wr_b = 1'b0;
		case (kind) inside
			K_RAM, K_ROM, K_ROM1, K_HW: ign = head_req.func && head_req.isolate;
			K_NONE: err = 1'b1;
			K_NULL: begin
				ign = head_req.func;
				err = !head_req.func;
			end
			K_CDVD: err = (head_req.size != SZ_BYTE);
			K_SPU2: err = (head_req.size != SZ_HALF);
			K_BIU: begin
				if (head_req.func) begin
					if (head_req.size != SZ_WORD) begin
						err = 1'b1;
					end else if (!lt_lo) begin
						err = !(ge_mid && lt_hi);
						if (ge_mid) begin
							wr_cctrl = (a == BIU_CCTRL);
							wr_a = (a == BIU_REG_A);
							wr_b = (a == BIU_REG_B);
						end
					end
				end else if (!lt_lo) begin
					err = !(ge_mid && lt_hi);
					if (a == BIU_CCTRL)
						rd = cctrl_q & wmask;
					else if (is_half && a == BIU_CCTRL + 32'd2)
						rd = {16'h0, cctrl_q[31:16]};
					else if (a == BIU_REG_A)
						rd = reg_a_q & wmask;
					else if (is_half && a == BIU_REG_A + 32'd2)
						rd = {16'h0, reg_a_q[31:16]};
					else if (a == BIU_REG_B)
						rd = reg_b_q & wmask;
					else if (is_half && a == BIU_REG_B + 32'd2)
						rd = {16'h0, reg_b_q[31:16]};
					if (err)
						rd = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cctrl_q <= '0;
			reg_a_q <= '0;
			reg_b_q <= '0;
			spm_q <= SPM_MAP;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (pop && wr_cctrl) begin
				cctrl_q <= wval;
				if (wval[3] != cctrl_q[3] || wval[7] != cctrl_q[7]) begin
					if (!wval[3])
						spm_q <= SPM_UNMAP;
					else if (wval[7])
						spm_q <= SPM_DIRECT;
					else
						spm_q <= SPM_NULL;
				end
			end
			if (pop && wr_a)
				reg_a_q <= head_req.write_data;
			if (pop && wr_b)
				reg_b_q <= head_req.write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			target_q <= (kind == K_NULL) ? K_NONE : kind;
			offset_q <= off;
			err_q <= err;
			ign_q <= ign;
			rdata_q <= rd;
		end
	end

	assign out_valid = out_valid_q;
	assign target = target_q;
	assign offset = offset_q;
	assign bus_error = err_q;
	assign ignored = ign_q;
	assign read_data = rdata_q;

endmodule

// File: rtl/bus_address_decoder_with_biu_regs_unit.sv
// Top level of the bus address decoder with BIU register file.
// Instantiates biudec_front, biudec_queue and biudec_back; depends on biudec_pkg.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  func, size_code, address, write_data, isolate
//   out      out_valid / out_stall target, offset, bus_error, ignored, read_data
//
// One request per cycle sustained while out_stall is low; an accepted request is written into
// the queue, then into the output register when popped, and out_stall holds it back.
// Page decode is done on entry; scratchpad mode and BIU registers act in the back end.
// Reset clears the BIU registers to zero and the scratchpad to mapped mode (SPM_MAP).
// in_stall rises only when the queue holds two requests behind a stalled output.
module bus_address_decoder_with_biu_regs_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [1:0]  size_code,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	input  logic        isolate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  target,
	output logic [21:0] offset,
	output logic        bus_error,
	output logic        ignored,
	output logic [31:0] read_data
);
	import biudec_pkg::*;

	req_t fe_req;
	req_t head_req;
	logic push, pop, q_full, head_valid;

	biudec_front u_front (
		.in_valid   (in_valid),
		.q_full     (q_full),
		.func       (func),
		.size_code  (size_code),
		.address    (address),
		.write_data (write_data),
		.isolate    (isolate),
		.in_stall   (in_stall),
		.push       (push),
		.req        (fe_req)
	);

	biudec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (fe_req),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_req   (head_req)
	);

	biudec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_req   (head_req),
		.out_stall  (out_stall),
		.pop        (pop),
		.out_valid  (out_valid),
		.target     (target),
		.offset     (offset),
		.bus_error  (bus_error),
		.ignored    (ignored),
		.read_data  (read_data)
	);

endmodule
